### rtl/dtrs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dtrs_pkg
// shared types and constants of the decision trail stack
// ----------------------------------------------------------------------------
package dtrs_pkg;

	localparam int LIT_W = 9;
	localparam int VAR_W = LIT_W - 1;

	typedef enum logic [1:0] {
		KIND_DECIDE    = 2'd0,
		KIND_BACKTRACK = 2'd1,
		KIND_CLEAR     = 2'd2
	} kind_t;

	typedef struct packed {
		logic [VAR_W-1:0] var_idx;
		logic             pos_tried;
		logic             neg_tried;
		logic             last_neg;
	} trail_entry_t;

	typedef struct packed {
		logic push;
		logic pop;
		logic load;
	} cell_ctrl_t;

endpackage
`default_nettype wire

### rtl/dpll_decision_trail_stack.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dpll_decision_trail_stack
// decision trail of a chronological backtracking solver, as a row of cells
// ----------------------------------------------------------------------------
// slave channel: one transfer per operation, tuser holds the kind (decide,
// backtrack, clear), tdata the decided literal (variable * 2 + negated).
// master channel: result transfers, tlast on the final result of an operation.
// decide and clear give one result, registered on the input transfer; a new
// operation can be taken in the same cycle as that result is taken, so these
// run at one operation per cycle while the receiver takes every result.
// backtrack gives one result per popped entry, then a final one; the top cell
// is examined once per cycle unless stalled; the row shifts up one slot per pop.
// the trail lives in a row of STACK_DEPTH cells with the top entry in cell 0;
// a push shifts every cell down by one, a pop shifts every cell up by one.
// reset empties the trail and drops any pending result; cell contents stay
// undefined until pushed.
// when the receiver stalls, the result register holds and no new input or
// backtrack step proceeds until it is taken.
// ----------------------------------------------------------------------------
module dpll_decision_trail_stack
	import dtrs_pkg::*;
#(
	parameter int STACK_DEPTH = 32
) (
	input  wire  logic        clk,
	input  wire  logic        arst_n,
	input  wire  logic        s_tvalid,
	output       logic        s_tready,
	input  wire  logic [15:0] s_tdata,  // literal_code[8:0], zero pad
	input  wire  logic [1:0]  s_tuser,  // kind[1:0]
	output       logic        m_tvalid,
	input  wire  logic        m_tready,
	output       logic [23:0] m_tdata,  // unassign_literal[8:0], suggest_literal[17:9], pad
	output       logic [3:0]  m_tuser,  // unassign_valid, suggest_valid, unsat, overflow
	output       logic        m_tlast
);

	localparam int CNT_W = $clog2(STACK_DEPTH + 1);
	localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(STACK_DEPTH);

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_BT   = 2'b10
	} state_t;

	state_t           state_q, state_d;
	logic [CNT_W-1:0] count_q, count_d;
	logic             out_valid_q;
	logic [LIT_W-1:0] unassign_lit_q, suggest_lit_q;
	logic             unassign_valid_q, suggest_valid_q, unsat_q, overflow_q, last_q;

	trail_entry_t     cell_entry [STACK_DEPTH];
	trail_entry_t     top_e, new_e;
	cell_ctrl_t       row_ctrl;

	logic             out_free, accept;
	logic [LIT_W-1:0] lit;
	logic [VAR_W-1:0] lit_var;
	logic             lit_neg, top_match;

	logic             emit, e_uv, e_sv, e_unsat, e_ovf, e_last;
	logic [LIT_W-1:0] e_ul, e_sl;

	assign out_free = !out_valid_q || m_tready;
	assign s_tready = (state_q == S_IDLE) && out_free;
	assign accept   = s_tvalid && s_tready;

	assign lit       = s_tdata[LIT_W-1:0];
	assign lit_var   = lit[LIT_W-1:1];
	assign lit_neg   = lit[0];
	assign top_e     = cell_entry[0];
	assign top_match = (count_q != '0) && (top_e.var_idx == lit_var);

	always_comb begin
		state_d  = state_q;
		count_d  = count_q;
		row_ctrl = '0;
		new_e    = top_e;
		emit     = 1'b0;
		e_uv     = 1'b0;
		e_ul     = '0;
		e_sv     = 1'b0;
		e_sl     = '0;
		e_unsat  = 1'b0;
		e_ovf    = 1'b0;
		e_last   = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					case (s_tuser)
						KIND_DECIDE: begin
							emit   = 1'b1;
							e_last = 1'b1;
							if (top_match && lit_neg && top_e.pos_tried) begin
								new_e.neg_tried = 1'b1;
								new_e.last_neg  = 1'b1;
								row_ctrl.load   = 1'b1;
							end else if (top_match && !lit_neg && top_e.neg_tried) begin
								new_e.pos_tried = 1'b1;
								new_e.last_neg  = 1'b0;
								row_ctrl.load   = 1'b1;
							end else if (count_q == DEPTH_C) begin
								e_ovf = 1'b1;
							end else begin
								new_e.var_idx   = lit_var;
								new_e.pos_tried = !lit_neg;
								new_e.neg_tried = lit_neg;
								new_e.last_neg  = lit_neg;
								row_ctrl.push   = 1'b1;
								count_d         = count_q + 1'b1;
							end
						end
						KIND_BACKTRACK: begin
							state_d = S_BT;
						end
						KIND_CLEAR: begin
							emit    = 1'b1;
							e_last  = 1'b1;
							count_d = '0;
						end
						default: begin
							emit   = 1'b1;
							e_last = 1'b1;
						end
					endcase
				end
			end
			S_BT: begin
				if (out_free) begin
					emit = 1'b1;
					if (count_q == '0) begin
						e_unsat = 1'b1;
						e_last  = 1'b1;
						state_d = S_IDLE;
					end else if (top_e.pos_tried && top_e.neg_tried) begin
						e_uv         = 1'b1;
						e_ul         = {top_e.var_idx, top_e.last_neg};
						row_ctrl.pop = 1'b1;
						count_d      = count_q - 1'b1;
					end else begin
						e_uv    = 1'b1;
						e_ul    = {top_e.var_idx, !top_e.pos_tried};
						e_sv    = 1'b1;
						e_sl    = {top_e.var_idx, top_e.pos_tried};
						e_last  = 1'b1;
						state_d = S_IDLE;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
		cell_ctrl_t   c_ctrl;
		trail_entry_t c_prev, c_next;
		assign c_ctrl.push = row_ctrl.push;
		assign c_ctrl.pop  = row_ctrl.pop;
		if (i == 0) begin : g_head
			assign c_ctrl.load = row_ctrl.load;
			assign c_prev      = new_e;
		end else begin : g_body
			assign c_ctrl.load = 1'b0;
			assign c_prev      = cell_entry[i-1];
		end
		if (i == STACK_DEPTH - 1) begin : g_tail
			assign c_next = cell_entry[i];
		end else begin : g_link
			assign c_next = cell_entry[i+1];
		end
		dtrs_cell u_cell (
			.clk        (clk),
			.ctrl       (c_ctrl),
			.prev_entry (c_prev),
			.next_entry (c_next),
			.entry      (cell_entry[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			unassign_valid_q <= e_uv;
			unassign_lit_q   <= e_ul;
			suggest_valid_q  <= e_sv;
			suggest_lit_q    <= e_sl;
			unsat_q          <= e_unsat;
			overflow_q       <= e_ovf;
			last_q           <= e_last;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {6'd0, suggest_lit_q, unassign_lit_q};
	assign m_tuser  = {overflow_q, unsat_q, suggest_valid_q, unassign_valid_q};
	assign m_tlast  = last_q;

	// trail never holds more than its depth
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= DEPTH_C)
		else $error("trail count beyond depth");

	// outside a backtrack every pending result is the final one of its transfer
	a_idle_last: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE && out_valid_q) |-> last_q)
		else $error("non-final result pending while idle");

	// each pop removes exactly one entry
	a_pop_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_BT && row_ctrl.pop) |=> (count_q == $past(count_q) - 1'b1))
		else $error("pop did not shrink the trail by one");

	// unsat only reported with an empty trail
	a_unsat_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && unsat_q) |-> (count_q == '0))
		else $error("unsat with a non-empty trail");

endmodule
`default_nettype wire

### rtl/dtrs_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dtrs_cell
// one trail slot; shifts down on push, up on pop, loads in place on update
// ----------------------------------------------------------------------------
module dtrs_cell
	import dtrs_pkg::*;
(
	input  wire  logic         clk,
	input  wire  cell_ctrl_t   ctrl,
	input  wire  trail_entry_t prev_entry,
	input  wire  trail_entry_t next_entry,
	output       trail_entry_t entry
);

	trail_entry_t entry_q;

	always_ff @(posedge clk) begin
		if (ctrl.push || ctrl.load) begin
			entry_q <= prev_entry;
		end else if (ctrl.pop) begin
			entry_q <= next_entry;
		end
	end

	assign entry = entry_q;

endmodule
`default_nettype wire
